// File: hdl/sparse_segment_gather_sum_assert.svh
// Assertion macros used by the block's top module.
`ifndef SPARSE_SEGMENT_GATHER_SUM_ASSERT_SVH
`define SPARSE_SEGMENT_GATHER_SUM_ASSERT_SVH

// Check a property at each rising edge outside reset.
`define SSGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at each rising edge, during reset too.
`define SSGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/ssgs_pkg.sv
package ssgs_pkg;

  localparam int unsigned TABLE_ROWS = 1024;
  localparam int unsigned ROW_WIDTH  = 4;
  localparam int unsigned IO_LANES   = 4;

  localparam int unsigned ROW_AW    = $clog2(TABLE_ROWS);
  localparam int unsigned ROW_IDX_W = 10;
  localparam int unsigned SEG_W     = 16;
  localparam int unsigned NSEG_W    = 17;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned SUM_W     = 32;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_GATHER = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [ROW_WIDTH-1:0]    row_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef sum_t [ROW_WIDTH-1:0]     sum_vec_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic acc;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic             load;
    logic             error;
    logic [SEG_W-1:0] segment;
  } out_load_t;

  // wrap a row index into the table, one compare and subtract per index bit
  function automatic logic [ROW_AW-1:0] row_wrap(input logic [ROW_IDX_W-1:0] idx);
    logic [31:0] v;
    v = 32'(idx);
    for (int s = ROW_IDX_W - 1; s >= 0; s--) begin
      if (v >= (32'(TABLE_ROWS) << s)) begin
        v = v - (32'(TABLE_ROWS) << s);
      end
    end
    return v[ROW_AW-1:0];
  endfunction

endpackage

// File: hdl/ssgs_row_mem.sv
module ssgs_row_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ssgs_pkg::ROW_AW-1:0] waddr_i,
  input  ssgs_pkg::row_t              wdata_i,
  input  logic                        re_i,
  input  logic [ssgs_pkg::ROW_AW-1:0] raddr_i,
  output ssgs_pkg::row_t              rdata_o
);

  ssgs_pkg::row_t mem_q [ssgs_pkg::TABLE_ROWS];
  ssgs_pkg::row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ssgs_lane.sv
module ssgs_lane (
  input  logic                 clk_i,
  input  ssgs_pkg::lane_ctrl_t ctrl_i,
  input  ssgs_pkg::elem_t      elem_i,
  output ssgs_pkg::sum_t       sum_o
);

  ssgs_pkg::sum_t               sum_q;
  ssgs_pkg::sum_t               sum_d;
  ssgs_pkg::sum_t               base;
  logic signed [ssgs_pkg::SUM_W:0] wide;

  always_comb begin
    base = ctrl_i.clear ? '0 : sum_q;
    wide = $signed({base[ssgs_pkg::SUM_W-1], base}) + (ssgs_pkg::SUM_W + 1)'(elem_i);
    if (wide[ssgs_pkg::SUM_W] != wide[ssgs_pkg::SUM_W-1]) begin
      sum_d = wide[ssgs_pkg::SUM_W] ? ssgs_pkg::SUM_MIN : ssgs_pkg::SUM_MAX;
    end else begin
      sum_d = wide[ssgs_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: hdl/ssgs_out.sv
module ssgs_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssgs_pkg::out_load_t        load_i,
  input  ssgs_pkg::sum_vec_t         sums_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [ssgs_pkg::SEG_W-1:0] out_segment_o,
  output logic signed [31:0]         sum_0_o,
  output logic signed [31:0]         sum_1_o,
  output logic signed [31:0]         sum_2_o,
  output logic signed [31:0]         sum_3_o,
  output logic                       range_error_o
);

  logic                       valid_q;
  logic                       valid_d;
  logic [ssgs_pkg::SEG_W-1:0] seg_q;
  logic                       err_q;
  ssgs_pkg::sum_t             sum_q [ssgs_pkg::IO_LANES];
  ssgs_pkg::sum_t             sum_d [ssgs_pkg::IO_LANES];

  // merge lanes onto the output word; missing lanes and rejects read zero
  for (genvar k = 0; k < ssgs_pkg::IO_LANES; k++) begin : g_merge
    if (k < ssgs_pkg::ROW_WIDTH) begin : g_lane
      assign sum_d[k] = load_i.error ? '0 : sums_i[k];
    end else begin : g_zero
      assign sum_d[k] = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      seg_q <= load_i.segment;
      err_q <= load_i.error;
      for (int k = 0; k < ssgs_pkg::IO_LANES; k++) begin
        sum_q[k] <= sum_d[k];
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign out_segment_o = seg_q;
  assign range_error_o = err_q;
  assign sum_0_o       = sum_q[0];
  assign sum_1_o       = sum_q[1];
  assign sum_2_o       = sum_q[2];
  assign sum_3_o       = sum_q[3];

endmodule

// File: hdl/sparse_segment_gather_sum.sv
// Embedding-bag engine: gathers table rows and forms saturated per-segment lane sums.
// Input channel (in_valid_i/in_ready_o) carries one command word: write a table row,
// gather a row into the held segment, or flush the pending sums.
// Output channel (out_valid_o/out_ready_i) carries one result word: a finished
// segment sum, or a rejected segment id with range_error_o set and zero sums.
// Config: cfg_we_i loads num_segments from cfg_data_i; write it while idle.
// Each result word is registered: it is valid in the cycle after the command word that causes it.
// Write and flush leave input ready; a gather does the registered table read, then
// the lane adds in the accumulators, and holds off input until the adds are done.
// Input is taken while a result word waits only when the receiver takes it in the
// same cycle; a stalled receiver holds the result and stalls the input channel.
// Reset: no segment pending, held segment 0, num_segments 65536. The table is not
// cleared; gathering a row never written returns undefined sums.
module sparse_segment_gather_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [9:0]          row_index_i,
  input  logic [15:0]         segment_id_i,
  input  logic signed [15:0]  elem_0_i,
  input  logic signed [15:0]  elem_1_i,
  input  logic signed [15:0]  elem_2_i,
  input  logic signed [15:0]  elem_3_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         out_segment_o,
  output logic signed [31:0]  sum_0_o,
  output logic signed [31:0]  sum_1_o,
  output logic signed [31:0]  sum_2_o,
  output logic signed [31:0]  sum_3_o,
  output logic                range_error_o
);

`include "sparse_segment_gather_sum_assert.svh"

  ssgs_pkg::cmd_e                cmd;
  logic                          accept;
  logic                          slot_free;
  logic                          seg_ok;
  logic                          emit_prev;
  logic [ssgs_pkg::ROW_AW-1:0]   row_addr;
  ssgs_pkg::elem_t               elem_in [ssgs_pkg::IO_LANES];
  ssgs_pkg::row_t                wdata;
  ssgs_pkg::row_t                rdata;
  logic                          mem_we;
  logic                          mem_re;
  ssgs_pkg::out_load_t           out_load;
  ssgs_pkg::lane_ctrl_t          lane_ctrl;
  ssgs_pkg::sum_vec_t            lane_sum;

  logic [ssgs_pkg::NSEG_W-1:0]   num_segments_q;
  logic [ssgs_pkg::SEG_W-1:0]    held_segment_q;
  logic [ssgs_pkg::SEG_W-1:0]    held_segment_d;
  logic                          sum_pending_q;
  logic                          sum_pending_d;
  logic                          busy_q;
  logic                          busy_d;
  logic                          clear_q;
  logic                          clear_d;

  assign cmd        = ssgs_pkg::cmd_e'(command_i);
  assign slot_free  = !out_valid_o || out_ready_i;
  assign in_ready_o = !busy_q && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign seg_ok     = {1'b0, segment_id_i} < num_segments_q;
  assign emit_prev  = sum_pending_q && (segment_id_i > held_segment_q);
  assign row_addr   = ssgs_pkg::row_wrap(row_index_i);

  assign elem_in[0] = elem_0_i;
  assign elem_in[1] = elem_1_i;
  assign elem_in[2] = elem_2_i;
  assign elem_in[3] = elem_3_i;

  for (genvar k = 0; k < ssgs_pkg::ROW_WIDTH; k++) begin : g_wdata
    if (k < ssgs_pkg::IO_LANES) begin : g_in
      assign wdata[k] = elem_in[k];
    end else begin : g_pad
      assign wdata[k] = '0;
    end
  end

  always_comb begin
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    out_load.load    = 1'b0;
    out_load.error   = 1'b0;
    out_load.segment = held_segment_q;
    held_segment_d   = held_segment_q;
    sum_pending_d    = sum_pending_q;
    busy_d           = 1'b0;
    clear_d          = clear_q;
    case (cmd)
      ssgs_pkg::CMD_WRITE: begin
        mem_we = accept;
      end
      ssgs_pkg::CMD_GATHER: begin
        if (accept) begin
          if (!seg_ok) begin
            out_load.load    = 1'b1;
            out_load.error   = 1'b1;
            out_load.segment = segment_id_i;
          end else begin
            mem_re         = 1'b1;
            busy_d         = 1'b1;
            clear_d        = !sum_pending_q || emit_prev;
            held_segment_d = segment_id_i;
            sum_pending_d  = 1'b1;
            out_load.load  = emit_prev;
          end
        end
      end
      ssgs_pkg::CMD_FLUSH: begin
        if (accept && sum_pending_q) begin
          out_load.load = 1'b1;
          sum_pending_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_segments_q <= ssgs_pkg::NSEG_W'(65536);
      held_segment_q <= '0;
      sum_pending_q  <= 1'b0;
      busy_q         <= 1'b0;
      clear_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_segments_q <= cfg_data_i;
      end
      held_segment_q <= held_segment_d;
      sum_pending_q  <= sum_pending_d;
      busy_q         <= busy_d;
      clear_q        <= clear_d;
    end
  end

  assign lane_ctrl.acc   = busy_q;
  assign lane_ctrl.clear = clear_q;

  ssgs_row_mem u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (row_addr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (row_addr),
    .rdata_o (rdata)
  );

  for (genvar k = 0; k < ssgs_pkg::ROW_WIDTH; k++) begin : g_lane
    ssgs_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .elem_i (rdata[k]),
      .sum_o  (lane_sum[k])
    );
  end

  ssgs_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .sums_i        (lane_sum),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_segment_o (out_segment_o),
    .sum_0_o       (sum_0_o),
    .sum_1_o       (sum_1_o),
    .sum_2_o       (sum_2_o),
    .sum_3_o       (sum_3_o),
    .range_error_o (range_error_o)
  );

  `SSGS_ASSERT(a_busy_one_cycle, busy_q |=> !busy_q, "accumulate ran longer than one cycle")
  `SSGS_ASSERT(a_no_accept_busy, busy_q |-> !in_ready_o, "word accepted during accumulate")
  `SSGS_ASSERT(a_load_slot_free, out_load.load |-> slot_free, "result overwrote a waiting word")
  `SSGS_ASSERT(a_reject_zero, (out_valid_o && range_error_o) |-> (sum_0_o == 0 && sum_1_o == 0 && sum_2_o == 0 && sum_3_o == 0), "reject word carries sums")
  `SSGS_ASSERT_ALWAYS(a_busy_pending, rst_ni |-> (!busy_q || sum_pending_q), "accumulate without pending segment")

endmodule
